// ----- sv/gcns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcns_pkg
// Shared types and constants of the grid cell neighbour search.
// ----------------------------------------------------------------------------
package gcns_pkg;

    localparam int MAX_PARTICLES  = 1024;
    localparam int GRID_COLS      = 64;
    localparam int GRID_ROWS      = 32;
    localparam int CELL_CAPACITY  = 32;
    localparam int MAX_NEIGHBOURS = 64;

    localparam int IDX_W  = 10;
    localparam int CX_W   = 6;
    localparam int CY_W   = 5;
    localparam int CELL_W = CX_W + CY_W;
    localparam int SLOT_W = 5;
    localparam int FILL_W = 6;
    localparam int MEM_AW = CELL_W + SLOT_W;
    localparam int CNT_W  = 7;
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;

    localparam logic [2:0] CFG_CELL_SIZE    = 3'd0;
    localparam logic [2:0] CFG_RADIUS_SQ    = 3'd1;
    localparam logic [2:0] CFG_CLAMP_LOW    = 3'd2;
    localparam logic [2:0] CFG_CLAMP_HIGH_X = 3'd3;
    localparam logic [2:0] CFG_CLAMP_HIGH_Y = 3'd4;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] particle_index;
        logic [15:0]      pos_x;
        logic [15:0]      pos_y;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] neighbour_index;
        logic [31:0]      dist_sq;
        logic [CX_W-1:0]  cell_x;
        logic [CY_W-1:0]  cell_y;
        logic [1:0]       status;
        logic             list_overflow;
        logic             last;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_QPOS, ST_QPOSW, ST_PREP, ST_DIV, ST_LOC,
        ST_IFILL, ST_IWR, ST_QCELL, ST_QFILL, ST_QMEM, ST_DRAIN, ST_FINAL
    } t_state;

endpackage
`default_nettype wire

// ----- sv/grid_cell_neighbour_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_neighbour_search
// Cell-list neighbour finder: clear, insert and 3x3 fixed-radius query.
//
// Input channel (i_in_valid / o_in_stall / i_in) takes one command per
// transfer; the output channel (o_out_valid / i_out_stall / o_out) gives
// one or more results per clear, insert or query command, the final one
// flagged last; a command of any other mode gives none. One command at a
// time. An insert runs the 16-step cell divider and then a fill
// read-modify-write. A query runs the same divider, then visits each of
// the nine cells: a cell in the grid has its fill read and then its members
// read one after another through the single read port of the member memory;
// a cell outside the grid is skipped. The distance pipeline then drains.
// Clear sweeps the fill memory at one cell per cycle. After reset the same
// sweep runs with the input stalled and no result; configuration writes
// are taken at any time.
// A stall on the output freezes the whole walk until the result moves.
// ----------------------------------------------------------------------------
module grid_cell_neighbour_search (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_idx,
    input  wire [31:0]           i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire gcns_pkg::t_in   i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output gcns_pkg::t_out       o_out
);
    import gcns_pkg::*;

    logic [15:0] r_cell_size, r_clamp_low, r_clamp_hx, r_clamp_hy;
    logic [31:0] r_radius_sq;

    logic [FILL_W-1:0] fill_mem [NUM_CELLS];
    logic [IDX_W-1:0]  memb_mem [2**MEM_AW];
    logic [31:0]       pos_mem  [MAX_PARTICLES];
    logic [FILL_W-1:0] r_fill_rd;
    logic [IDX_W-1:0]  r_memb_rd;
    logic [31:0]       r_pos_rd;

    t_state r_state, n_state;
    logic [CELL_W-1:0] r_clr_cnt;
    logic              r_clr_res;
    logic [1:0]        r_mode;
    logic [IDX_W-1:0]  r_p;
    logic [15:0]       r_x, r_y;
    logic [15:0]       r_qx, r_qy, r_rx, r_ry;
    logic [3:0]        r_dcnt;
    logic [CX_W-1:0]   r_cx;
    logic [CY_W-1:0]   r_cy;
    logic [1:0]        r_ox, r_oy;
    logic [CELL_W-1:0] r_cell;
    logic [FILL_W-1:0] r_n;
    logic [SLOT_W-1:0] r_i;
    logic              r_va, r_vb, r_vc;
    logic [IDX_W-1:0]  r_qb, r_qc;
    logic [31:0]       r_dx2, r_dy2;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    t_out              r_pend;
    logic              r_pend_v;
    t_out              r_res;
    t_out              r_out;
    logic              r_out_v;

    logic              adv, accept, in_grid, cell_ok, last_cell, hit, issue, out_set;
    logic [15:0]       cs, clx, cly;
    logic [16:0]       remx, remy;
    logic              gex, gey;
    logic [8:0]        nx9, ny9;
    logic [CELL_W-1:0] ncell;
    logic [FILL_W-1:0] nfill;
    logic signed [16:0] dx, dy;
    logic signed [33:0] dx2, dy2;
    logic [32:0]       dsum;
    logic              fill_we, fill_re, memb_we, pos_re;
    logic [CELL_W-1:0] fill_wa, fill_ra;
    logic [FILL_W-1:0] fill_wd;
    logic [IDX_W-1:0]  pos_ra;

    function automatic logic [15:0] clampv(input logic [15:0] v, input logic [15:0] lo,
                                           input logic [15:0] hi);
        logic [15:0] t;
        t = (v < hi) ? v : hi;
        return (t > lo) ? t : lo;
    endfunction

    assign adv    = !r_out_v || !i_out_stall;
    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_comb begin
        cs   = (r_cell_size == 16'd0) ? 16'd1 : r_cell_size;
        clx  = clampv(r_x, r_clamp_low, r_clamp_hx);
        cly  = clampv(r_y, r_clamp_low, r_clamp_hy);
        remx = {r_rx, r_qx[15]};
        remy = {r_ry, r_qy[15]};
        gex  = remx >= {1'b0, cs};
        gey  = remy >= {1'b0, cs};
        in_grid = (r_qx < 16'(GRID_COLS)) && (r_qy < 16'(GRID_ROWS));
        nx9  = {3'd0, r_cx} + {7'd0, r_ox};
        ny9  = {4'd0, r_cy} + {7'd0, r_oy};
        cell_ok = (nx9 != 9'd0) && (nx9 <= 9'(GRID_COLS))
               && (ny9 != 9'd0) && (ny9 <= 9'(GRID_ROWS));
        ncell = {CY_W'(ny9 - 9'd1), CX_W'(nx9 - 9'd1)};
        last_cell = (r_ox == 2'd2) && (r_oy == 2'd2);
        nfill = (r_fill_rd > FILL_W'(CELL_CAPACITY)) ? FILL_W'(CELL_CAPACITY) : r_fill_rd;
        dx   = $signed({1'b0, r_x}) - $signed({1'b0, r_pos_rd[15:0]});
        dy   = $signed({1'b0, r_y}) - $signed({1'b0, r_pos_rd[31:16]});
        dx2  = dx * dx;
        dy2  = dy * dy;
        dsum = {1'b0, r_dx2} + {1'b0, r_dy2};
        hit  = r_vc && (dsum <= {1'b0, r_radius_sq});
        issue = (r_state == ST_QMEM) && adv;
        out_set = adv && ((hit && (r_cnt != CNT_W'(MAX_NEIGHBOURS)) && r_pend_v)
                          || (r_state == ST_FINAL));
    end

    always_comb begin
        fill_we = 1'b0;
        fill_wa = r_clr_cnt;
        fill_wd = '0;
        fill_re = 1'b0;
        fill_ra = r_cell;
        memb_we = 1'b0;
        pos_re  = adv;
        pos_ra  = r_memb_rd;
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                fill_we = 1'b1;
                if (r_clr_cnt == CELL_W'(NUM_CELLS - 1)) begin
                    n_state = r_clr_res ? ST_FINAL : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.mode)
                        MODE_CLEAR:  n_state = ST_CLR;
                        MODE_INSERT: n_state = ST_PREP;
                        MODE_QUERY:  n_state = ST_QPOS;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_QPOS: begin
                pos_re  = 1'b1;
                pos_ra  = r_p;
                n_state = ST_QPOSW;
            end
            ST_QPOSW: n_state = ST_PREP;
            ST_PREP:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_dcnt == 4'd15) begin
                    n_state = ST_LOC;
                end
            end
            ST_LOC: begin
                if (!in_grid) begin
                    n_state = ST_FINAL;
                end else if (r_mode == MODE_INSERT) begin
                    n_state = ST_IFILL;
                end else begin
                    n_state = ST_QCELL;
                end
            end
            ST_IFILL: begin
                fill_re = 1'b1;
                fill_ra = {r_cy, r_cx};
                n_state = ST_IWR;
            end
            ST_IWR: begin
                fill_wa = {r_cy, r_cx};
                fill_wd = r_fill_rd + FILL_W'(1);
                if (r_fill_rd < FILL_W'(CELL_CAPACITY)) begin
                    fill_we = 1'b1;
                    memb_we = 1'b1;
                end
                n_state = ST_FINAL;
            end
            ST_QCELL: begin
                if (adv) begin
                    if (cell_ok) begin
                        fill_re = 1'b1;
                        fill_ra = ncell;
                        n_state = ST_QFILL;
                    end else if (last_cell) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_QFILL: begin
                if (adv) begin
                    if (nfill != '0) begin
                        n_state = ST_QMEM;
                    end else begin
                        n_state = last_cell ? ST_DRAIN : ST_QCELL;
                    end
                end
            end
            ST_QMEM: begin
                if (adv && ({1'b0, r_i} == r_n - FILL_W'(1))) begin
                    n_state = last_cell ? ST_DRAIN : ST_QCELL;
                end
            end
            ST_DRAIN: begin
                if (!r_va && !r_vb && !r_vc) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        if (fill_re) begin
            r_fill_rd <= fill_mem[fill_ra];
        end
        if (memb_we) begin
            memb_mem[{r_cy, r_cx, r_fill_rd[SLOT_W-1:0]}] <= r_p;
        end
        if (adv) begin
            r_memb_rd <= memb_mem[{r_cell, r_i}];
        end
        if (accept && (i_in.mode == MODE_INSERT)) begin
            pos_mem[i_in.particle_index] <= {i_in.pos_y, i_in.pos_x};
        end
        if (pos_re) begin
            r_pos_rd <= pos_mem[pos_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= 16'd320;
            r_radius_sq <= 32'd102400;
            r_clamp_low <= 16'd96;
            r_clamp_hx  <= 16'd15264;
            r_clamp_hy  <= 16'd8544;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_SIZE:    r_cell_size <= i_cfg_data[15:0];
                CFG_RADIUS_SQ:    r_radius_sq <= i_cfg_data;
                CFG_CLAMP_LOW:    r_clamp_low <= i_cfg_data[15:0];
                CFG_CLAMP_HIGH_X: r_clamp_hx  <= i_cfg_data[15:0];
                CFG_CLAMP_HIGH_Y: r_clamp_hy  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
        end else begin
            r_state   <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_clr_res <= 1'b0;
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_vc      <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (out_set) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (adv) begin
                r_va <= issue;
                r_vb <= r_va && (r_memb_rd != r_p);
                r_vc <= r_vb;
                r_qb <= r_memb_rd;
                r_qc <= r_qb;
                r_dx2 <= dx2[31:0];
                r_dy2 <= dy2[31:0];
                if (hit) begin
                    if (r_cnt == CNT_W'(MAX_NEIGHBOURS)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (r_pend_v) begin
                            r_out   <= r_pend;
                        end
                        r_pend_v <= 1'b1;
                        r_pend   <= '{found: 1'b1, neighbour_index: r_qc,
                                      dist_sq: dsum[31:0], cell_x: r_cx, cell_y: r_cy,
                                      status: STAT_OK, list_overflow: 1'b0, last: 1'b0};
                    end
                end
            end
            case (r_state)
                ST_CLR: begin
                    r_clr_cnt <= r_clr_cnt + CELL_W'(1);
                    r_res     <= '{default: '0, last: 1'b1};
                end
                ST_IDLE: begin
                    r_clr_cnt <= '0;
                    r_clr_res <= 1'b1;
                    if (accept) begin
                        r_mode <= i_in.mode;
                        r_p    <= i_in.particle_index;
                        r_x    <= i_in.pos_x;
                        r_y    <= i_in.pos_y;
                    end
                end
                ST_QPOSW: begin
                    r_x <= r_pos_rd[15:0];
                    r_y <= r_pos_rd[31:16];
                end
                ST_PREP: begin
                    r_qx   <= clx;
                    r_qy   <= cly;
                    r_rx   <= '0;
                    r_ry   <= '0;
                    r_dcnt <= '0;
                end
                ST_DIV: begin
                    r_rx   <= gex ? 16'(remx - {1'b0, cs}) : remx[15:0];
                    r_ry   <= gey ? 16'(remy - {1'b0, cs}) : remy[15:0];
                    r_qx   <= {r_qx[14:0], gex};
                    r_qy   <= {r_qy[14:0], gey};
                    r_dcnt <= r_dcnt + 4'd1;
                end
                ST_LOC: begin
                    r_cx     <= r_qx[CX_W-1:0];
                    r_cy     <= r_qy[CY_W-1:0];
                    r_ox     <= '0;
                    r_oy     <= '0;
                    r_cnt    <= '0;
                    r_ovf    <= 1'b0;
                    r_pend_v <= 1'b0;
                    r_res    <= in_grid
                        ? t_out'{default: '0, cell_x: r_qx[CX_W-1:0],
                                 cell_y: r_qy[CY_W-1:0], status: STAT_OK, last: 1'b1}
                        : t_out'{default: '0, status: STAT_OUTSIDE, last: 1'b1};
                end
                ST_IWR: begin
                    if (r_fill_rd >= FILL_W'(CELL_CAPACITY)) begin
                        r_res.status <= STAT_FULL;
                    end
                end
                ST_QCELL: begin
                    if (adv) begin
                        r_cell <= ncell;
                        if (!cell_ok && !last_cell) begin
                            r_oy <= (r_oy == 2'd2) ? 2'd0 : r_oy + 2'd1;
                            r_ox <= (r_oy == 2'd2) ? r_ox + 2'd1 : r_ox;
                        end
                    end
                end
                ST_QFILL: begin
                    if (adv) begin
                        r_n <= nfill;
                        r_i <= '0;
                        if ((nfill == '0) && !last_cell) begin
                            r_oy <= (r_oy == 2'd2) ? 2'd0 : r_oy + 2'd1;
                            r_ox <= (r_oy == 2'd2) ? r_ox + 2'd1 : r_ox;
                        end
                    end
                end
                ST_QMEM: begin
                    if (adv) begin
                        r_i <= r_i + SLOT_W'(1);
                        if (({1'b0, r_i} == r_n - FILL_W'(1)) && !last_cell) begin
                            r_oy <= (r_oy == 2'd2) ? 2'd0 : r_oy + 2'd1;
                            r_ox <= (r_oy == 2'd2) ? r_ox + 2'd1 : r_ox;
                        end
                    end
                end
                ST_FINAL: begin
                    if (adv) begin
                        r_out <= r_pend_v ? {r_pend[$bits(t_out)-1:2], r_ovf, 1'b1} : r_res;
                        r_pend_v <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- test/grid_cell_neighbour_search_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_neighbour_search_test
// Self-checking bench: drives clear, insert, query and mode 3 commands with random
// gaps on both channels, predicts every result from an internal model of
// the cell grid, and compares each result in arrival order.
// ----------------------------------------------------------------------------
module grid_cell_neighbour_search_test;
    import gcns_pkg::*;

    class grid_scoreboard;
        logic [15:0] csize, clo, chx, chy;
        logic [31:0] rsq;
        logic [5:0]  fill [NUM_CELLS];
        logic [9:0]  members [NUM_CELLS*CELL_CAPACITY];
        logic [15:0] px [MAX_PARTICLES];
        logic [15:0] py [MAX_PARTICLES];
        t_out        pending[$];
        int          errors;
        int          n_results;

        function new();
            csize = 16'd320; rsq = 32'd102400; clo = 16'd96; chx = 16'd15264; chy = 16'd8544;
            foreach (fill[i]) fill[i] = '0;
            errors = 0;
            n_results = 0;
        endfunction

        function void queue_res(t_out r);
            pending = {pending, r};
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_CELL_SIZE:    csize = v[15:0];
                CFG_RADIUS_SQ:    rsq = v;
                CFG_CLAMP_LOW:    clo = v[15:0];
                CFG_CLAMP_HIGH_X: chx = v[15:0];
                CFG_CLAMP_HIGH_Y: chy = v[15:0];
                default: ;
            endcase
        endfunction

        function bit bin(logic [15:0] x, logic [15:0] y, output int cx, output int cy);
            int cs, tx, ty;
            cs = (csize == 16'd0) ? 1 : int'(csize);
            tx = (x < chx) ? int'(x) : int'(chx);
            tx = (tx > int'(clo)) ? tx : int'(clo);
            ty = (y < chy) ? int'(y) : int'(chy);
            ty = (ty > int'(clo)) ? ty : int'(clo);
            cx = tx / cs;
            cy = ty / cs;
            return cx < GRID_COLS && cy < GRID_ROWS;
        endfunction

        function t_out blank(int cx, int cy, logic [1:0] st);
            t_out r;
            r = '0;
            r.cell_x = CX_W'(cx);
            r.cell_y = CY_W'(cy);
            r.status = st;
            r.last = 1'b1;
            return r;
        endfunction

        function void note_command(t_in c);
            int cx, cy, cidx, n, q;
            longint dx, dy, d;
            t_out r;
            logic ovf;
            int cnt;
            case (c.mode)
                MODE_CLEAR: begin
                    foreach (fill[i]) fill[i] = '0;
                    queue_res(blank(0, 0, STAT_OK));
                end
                MODE_INSERT: begin
                    px[c.particle_index] = c.pos_x;
                    py[c.particle_index] = c.pos_y;
                    if (!bin(c.pos_x, c.pos_y, cx, cy)) begin
                        queue_res(blank(0, 0, STAT_OUTSIDE));
                    end else begin
                        cidx = cy * GRID_COLS + cx;
                        if (fill[cidx] >= CELL_CAPACITY) begin
                            queue_res(blank(cx, cy, STAT_FULL));
                        end else begin
                            members[cidx*CELL_CAPACITY + fill[cidx]] = c.particle_index;
                            fill[cidx]++;
                            queue_res(blank(cx, cy, STAT_OK));
                        end
                    end
                end
                MODE_QUERY: begin
                    if (!bin(px[c.particle_index], py[c.particle_index], cx, cy)) begin
                        queue_res(blank(0, 0, STAT_OUTSIDE));
                    end else begin
                        cnt = 0;
                        ovf = 1'b0;
                        for (int ox = -1; ox <= 1; ox++)
                            for (int oy = -1; oy <= 1; oy++) begin
                                if (cx+ox < 0 || cx+ox >= GRID_COLS ||
                                    cy+oy < 0 || cy+oy >= GRID_ROWS) continue;
                                cidx = (cy+oy) * GRID_COLS + cx + ox;
                                n = int'(fill[cidx]);
                                for (int i = 0; i < n; i++) begin
                                    q = int'(members[cidx*CELL_CAPACITY + i]);
                                    if (q == c.particle_index) continue;
                                    dx = longint'(px[c.particle_index]) - longint'(px[q]);
                                    dy = longint'(py[c.particle_index]) - longint'(py[q]);
                                    d = dx*dx + dy*dy;
                                    if (d <= rsq) begin
                                        if (cnt >= MAX_NEIGHBOURS) begin
                                            ovf = 1'b1;
                                            continue;
                                        end
                                        r = blank(cx, cy, STAT_OK);
                                        r.last = 1'b0;
                                        r.found = 1'b1;
                                        r.neighbour_index = 10'(q);
                                        r.dist_sq = d[31:0];
                                        queue_res(r);
                                        cnt++;
                                    end
                                end
                            end
                        if (cnt == 0) begin
                            queue_res(blank(cx, cy, STAT_OK));
                        end else begin
                            pending[pending.size()-1].list_overflow = ovf;
                            pending[pending.size()-1].last = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out a);
            t_out e;
            n_results++;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.found !== e.found || a.neighbour_index !== e.neighbour_index ||
                a.dist_sq !== e.dist_sq || a.cell_x !== e.cell_x ||
                a.cell_y !== e.cell_y || a.status !== e.status ||
                a.list_overflow !== e.list_overflow || a.last !== e.last) begin
                $display("%0t mismatch: expected %h, actual %h", $time, e, a);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    t_in         in_cmd = '0;
    logic        out_valid;
    logic        out_stall = 0;
    t_out        out_res;

    grid_scoreboard sb;
    longint cycles = 0;
    int     n_cmds = 0;
    bit     inserted [MAX_PARTICLES];
    int     known[$];

    localparam longint CYCLE_LIMIT = 10000000;

    grid_cell_neighbour_search uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_cmd),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_res)
    );

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[grid_cell_neighbour_search] ERROR");
            $finish;
        end
    end

    // receiver: one random wait per result
    initial begin
        int w;
        forever begin
            @(negedge clk);
            if (out_valid) begin
                w = $urandom_range(0, 9);
                if (w != 0) begin
                    out_stall <= 1'b1;
                    repeat (w) @(negedge clk);
                    out_stall <= 1'b0;
                end
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic send(logic [1:0] mode, logic [9:0] idx, logic [15:0] x, logic [15:0] y);
        t_in c;
        int gap;
        gap = $urandom_range(0, 9);
        repeat (gap) @(negedge clk);
        c.mode = mode;
        c.particle_index = idx;
        c.pos_x = x;
        c.pos_y = y;
        in_cmd = c;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_command(c);
        if (mode == MODE_INSERT && !inserted[idx]) begin
            inserted[idx] = 1;
            known.push_front(int'(idx));
        end
        n_cmds++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (2200) @(negedge clk);
    endtask

    function automatic logic [9:0] pick_known();
        return 10'(known[$urandom_range(0, known.size() - 1)]);
    endfunction

    task automatic random_phase(int count, int cluster);
        int r;
        logic [15:0] bx, by;
        bx = 16'($urandom_range(0, 15000));
        by = 16'($urandom_range(0, 8500));
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                send(MODE_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom));
            else if (r < 4)
                send(2'd3, 10'($urandom), 16'($urandom), 16'($urandom));
            else if (r < 55 || known.size() == 0) begin
                if (r < 8)
                    send(MODE_INSERT, 10'($urandom), 16'($urandom), 16'($urandom));
                else
                    send(MODE_INSERT, 10'($urandom_range(0, 1023)),
                         16'(bx + $urandom_range(0, cluster)),
                         16'(by + $urandom_range(0, cluster)));
            end else
                send(MODE_QUERY, pick_known(), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1;

        // directed: extremes, duplicate, mode 3, clear, zero cell size, full cell
        send(MODE_INSERT, 10'd0, 16'd0, 16'd0);
        send(MODE_INSERT, 10'd1023, 16'hFFFF, 16'hFFFF);
        send(MODE_INSERT, 10'd5, 16'd100, 16'd120);
        send(MODE_INSERT, 10'd5, 16'd100, 16'd120);
        send(MODE_INSERT, 10'd6, 16'd400, 16'd130);
        send(MODE_QUERY, 10'd5, 16'hFFFF, 16'h0);
        send(MODE_QUERY, 10'd1023, 16'h0, 16'hFFFF);
        send(2'd3, 10'h2AA, 16'h5555, 16'hAAAA);
        send(MODE_CLEAR, 10'h155, 16'hAAAA, 16'h5555);
        send(MODE_QUERY, 10'd0, 16'd0, 16'd0);
        drain();
        write_reg(CFG_CELL_SIZE, 32'd0);
        write_reg(CFG_CLAMP_HIGH_X, 32'd60);
        write_reg(CFG_CLAMP_HIGH_Y, 32'd20);
        write_reg(CFG_CLAMP_LOW, 32'd0);
        write_reg(CFG_RADIUS_SQ, 32'hFFFFFFFF);
        for (int k = 0; k < 6; k++) send(MODE_INSERT, 10'(100 + k), 16'd10, 16'd5);
        send(MODE_INSERT, 10'd200, 16'd200, 16'd3);
        send(MODE_QUERY, 10'd100, 16'd0, 16'd0);
        drain();
        write_reg(CFG_CELL_SIZE, 32'hFFFF);
        write_reg(CFG_CLAMP_LOW, 32'd200);
        for (int k = 0; k < 34; k++)
            send(MODE_INSERT, 10'(300 + k), 16'($urandom), 16'($urandom));
        send(MODE_QUERY, 10'd300, 16'd0, 16'd0);
        drain();

        // random phases under several settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_CELL_SIZE, ph == 0 ? 32'd320 : $urandom_range(16, 2000));
            write_reg(CFG_RADIUS_SQ, ph == 1 ? 32'd0 : $urandom_range(0, 400000));
            write_reg(CFG_CLAMP_LOW, ph == 2 ? 32'hFFFF : $urandom_range(0, 200));
            write_reg(CFG_CLAMP_HIGH_X, ph == 3 ? 32'hFFFF : $urandom_range(1000, 20000));
            write_reg(CFG_CLAMP_HIGH_Y, ph == 3 ? 32'hFFFF : $urandom_range(1000, 12000));
            send(MODE_CLEAR, 10'd0, 16'd0, 16'd0);
            random_phase(90, ph == 4 ? 3000 : 800);
            drain();
        end

        $display("%0d commands sent, %0d results checked over directed cases and five",
                 n_cmds, sb.n_results);
        $display("random register settings with random gaps and receiver waits");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[grid_cell_neighbour_search] OK");
        else
            $display("[grid_cell_neighbour_search] ERROR");
        $finish;
    end
endmodule
